// ===== rtl/line_camera_readout_sequencer_defines.svh =====
`ifndef LINE_CAMERA_READOUT_SEQUENCER_DEFINES_SVH
`define LINE_CAMERA_READOUT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LCRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lcrs_pkg.sv =====
`timescale 1ns / 1ps
package lcrs_pkg;

  localparam int CNT_W       = 12;
  localparam int DATA_W      = 16;
  localparam int OPC_W       = 2;
  localparam int PIX_IDX_W   = 8;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int LINE_PIXELS_DEF = 128;

  localparam logic [CNT_W-1:0] FRAME_END_RESET = 12'd600;

  // Register index is taken from paddr[2].
  localparam logic REG_FRAME_END = 1'b0;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DROP  = 2'd1,
    PH_READ  = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 item_acc;
    logic                 wr_en;
    logic                 wr_half;
    logic [CNT_W-1:0]     wr_idx;
    logic [DATA_W-1:0]    wr_data;
    logic                 rd_en;
    logic                 rd_half;
    logic [PIX_IDX_W-1:0] rd_idx;
    logic                 swap;
  } mem_req_t;

  typedef struct packed {
    logic sensor_clock;
    logic start_pulse;
    logic convert_start;
  } levels_t;

endpackage

// ===== rtl/lcrs_if.sv =====
`timescale 1ns / 1ps
interface lcrs_in_if;
  logic                         valid;
  logic                         ready;
  logic [lcrs_pkg::OPC_W-1:0]     opcode;
  logic [lcrs_pkg::DATA_W-1:0]    sample_value;
  logic [lcrs_pkg::PIX_IDX_W-1:0] pixel_index;

  modport source (output valid, output opcode, output sample_value, output pixel_index,
                  input ready);
  modport sink   (input valid, input opcode, input sample_value, input pixel_index,
                  output ready);
endinterface

interface lcrs_out_if;
  logic                      valid;
  logic                      ready;
  logic                      sensor_clock;
  logic                      start_pulse;
  logic                      convert_start;
  logic [lcrs_pkg::DATA_W-1:0] pixel_data;

  modport source (output valid, output sensor_clock, output start_pulse,
                  output convert_start, output pixel_data, input ready);
  modport sink   (input valid, input sensor_clock, input start_pulse,
                  input convert_start, input pixel_data, output ready);
endinterface

// ===== rtl/lcrs_ctrl.sv =====
`timescale 1ns / 1ps
`include "line_camera_readout_sequencer_defines.svh"
module lcrs_ctrl #(
  parameter int LINE_PIXELS = lcrs_pkg::LINE_PIXELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               item_acc,
  input  logic [lcrs_pkg::OPC_W-1:0]         opcode,
  input  logic [lcrs_pkg::DATA_W-1:0]        sample_value,
  input  logic [lcrs_pkg::PIX_IDX_W-1:0]     pixel_index,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lcrs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lcrs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lcrs_pkg::APB_DATA_W-1:0]    prdata,
  output lcrs_pkg::mem_req_t                 mem_req,
  output lcrs_pkg::levels_t                  levels
);
  import lcrs_pkg::*;

  localparam logic [CNT_W-1:0] LINE_CNT = CNT_W'(LINE_PIXELS);

  phase_t           phase_r, phase_nxt;
  logic             clk_lvl_r, clk_lvl_nxt;
  logic             start_r, start_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             half_r, half_nxt;
  logic [CNT_W-1:0] frame_end_r, frame_end_nxt;
  logic [CNT_W-1:0] count_inc;
  logic             conv;
  logic             swap;
  logic             wr_en;
  logic             rd_en;
  logic             cfg_wr;

  assign cfg_wr    = psel && penable && pwrite;
  assign count_inc = count_r + 1'b1;

  always_comb begin
    frame_end_nxt = frame_end_r;
    if (cfg_wr && paddr[2] == REG_FRAME_END) begin
      frame_end_nxt = pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAME_END) begin
      prdata = APB_DATA_W'(frame_end_r);
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    clk_lvl_nxt = clk_lvl_r;
    start_nxt   = start_r;
    count_nxt   = count_r;
    half_nxt    = half_r;
    conv        = 1'b0;
    swap        = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    if (item_acc) begin
      unique case (opcode)
        OP_TICK: begin
          clk_lvl_nxt = ~clk_lvl_r;
          unique case (phase_r)
            PH_START: begin
              if (!clk_lvl_nxt) begin
                start_nxt = 1'b1;
                count_nxt = '0;
                phase_nxt = PH_DROP;
              end
            end
            PH_DROP: begin
              if (clk_lvl_nxt) begin
                start_nxt = 1'b0;
                phase_nxt = PH_READ;
              end
            end
            PH_READ: begin
              if (!clk_lvl_nxt) begin
                conv = 1'b1;
                if (count_r >= LINE_CNT) begin
                  half_nxt  = ~half_r;
                  swap      = 1'b1;
                  phase_nxt = PH_WAIT;
                end
              end
            end
            PH_WAIT: begin
              if (clk_lvl_nxt) begin
                count_nxt = count_inc;
                if (count_inc >= frame_end_r) begin
                  phase_nxt = PH_START;
                end
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
        OP_SAMPLE: begin
          if (count_r < LINE_CNT) begin
            wr_en     = 1'b1;
            count_nxt = count_inc;
          end
        end
        OP_READ: rd_en = 1'b1;
        default: rd_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      clk_lvl_r   <= 1'b0;
      start_r     <= 1'b0;
      count_r     <= '0;
      half_r      <= 1'b0;
      frame_end_r <= FRAME_END_RESET;
    end else begin
      phase_r     <= phase_nxt;
      clk_lvl_r   <= clk_lvl_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
      half_r      <= half_nxt;
      frame_end_r <= frame_end_nxt;
    end
  end

  always_comb begin
    mem_req.item_acc = item_acc;
    mem_req.wr_en    = wr_en;
    mem_req.wr_half  = half_r;
    mem_req.wr_idx   = count_r;
    mem_req.wr_data  = sample_value;
    mem_req.rd_en    = rd_en;
    mem_req.rd_half  = ~half_r;
    mem_req.rd_idx   = pixel_index;
    mem_req.swap     = swap;
    levels.sensor_clock  = clk_lvl_nxt;
    levels.start_pulse   = start_nxt;
    levels.convert_start = conv;
  end

  // The start line is high exactly while the sequence waits for the high clock.
  `LCRS_ASSERT_NOW(a_start_in_drop, 1'b1, start_r == (phase_r == PH_DROP), "start line out of phase")
  // While a line is being taken, the count never passes the line length.
  `LCRS_ASSERT_NOW(a_count_bound, (phase_r == PH_DROP) || (phase_r == PH_READ), count_r <= LINE_CNT, "line count beyond line length")
  // A half swap always lands in the wait phase with the other half selected.
  `LCRS_ASSERT_NEXT(a_swap_wait, swap, (phase_r == PH_WAIT) && (half_r != $past(half_r)), "swap without wait entry")

endmodule

// ===== rtl/lcrs_store.sv =====
`timescale 1ns / 1ps
module lcrs_store #(
  parameter int LINE_PIXELS = lcrs_pkg::LINE_PIXELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcrs_pkg::mem_req_t          mem_req,
  output logic [lcrs_pkg::DATA_W-1:0] rd_data
);
  import lcrs_pkg::*;

  localparam int DEPTH  = 2 * LINE_PIXELS;
  localparam int IDX_W  = $clog2(LINE_PIXELS);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] HALF_BASE = ADDR_W'(LINE_PIXELS);
  localparam logic [CNT_W-1:0]  LINE_CNT  = CNT_W'(LINE_PIXELS);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic              rd_ok_r, rd_ok_nxt;
  logic [1:0]        full_r, full_nxt;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_off;
  logic [ADDR_W-1:0] rd_off;

  assign wr_off  = ADDR_W'(IDX_W'(mem_req.wr_idx));
  assign rd_off  = ADDR_W'(IDX_W'(mem_req.rd_idx));
  assign wr_addr = mem_req.wr_half ? (HALF_BASE + wr_off) : wr_off;
  assign rd_addr = mem_req.rd_half ? (HALF_BASE + rd_off) : rd_off;

  // A half becomes readable only after it has been filled end to end and
  // swapped out; before that its entries read as zero.
  always_comb begin
    full_nxt = full_r;
    if (mem_req.swap) begin
      full_nxt[mem_req.wr_half] = 1'b1;
    end
    rd_ok_nxt = rd_ok_r;
    if (mem_req.item_acc) begin
      rd_ok_nxt = mem_req.rd_en && full_r[mem_req.rd_half] &&
                  (CNT_W'(mem_req.rd_idx) < LINE_CNT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      full_r  <= full_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

// ===== rtl/line_camera_readout_sequencer.sv =====
`timescale 1ns / 1ps
// Line camera readout sequencer.
// Input items carry an opcode: a clock tick advances the sensor clock and the
// start/convert sequence, a sample item stores one converter result into the
// half being filled (dropped once the line is full), and a read item fetches
// one pixel from the finished half (indexes past the line length return zero).
// Every accepted item yields exactly one result item with the sensor clock and
// start levels after the item, the convert request and the pixel data.
// Throughput is one item per clock while the output is not stalled. A result
// passes the synchronous line-store read and then the output register before
// it appears on the output channel.
// The input side keeps accepting while a result waits in the output register;
// when both the read stage and the output register are full and the receiver
// holds ready low, in_ch.ready drops until the output drains.
// Reset (rst_n low, synchronous) puts the sequencer in the start phase with
// both lines low, clears the line count and the frame end register to 600, and
// marks both store halves unwritten so they read as zero until filled.
// The frame end register sits at byte address 0 of the APB port.
module line_camera_readout_sequencer #(
  parameter int LINE_PIXELS = lcrs_pkg::LINE_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lcrs_in_if.sink                         in_ch,
  lcrs_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcrs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lcrs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lcrs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lcrs_pkg::*;

  mem_req_t          mem_req;
  levels_t           levels;
  logic [DATA_W-1:0] rd_data;
  logic              item_acc;
  logic              s1_move;
  logic              s1_valid_r, s1_valid_nxt;
  levels_t           s1_lvl_r;
  logic              out_valid_r, out_valid_nxt;
  levels_t           out_lvl_r;
  logic [DATA_W-1:0] out_data_r;

  assign pready   = 1'b1;
  assign s1_move  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign item_acc = in_ch.valid && in_ch.ready;

  lcrs_ctrl #(.LINE_PIXELS(LINE_PIXELS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_acc     (item_acc),
    .opcode       (in_ch.opcode),
    .sample_value (in_ch.sample_value),
    .pixel_index  (in_ch.pixel_index),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .mem_req      (mem_req),
    .levels       (levels)
  );

  lcrs_store #(.LINE_PIXELS(LINE_PIXELS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (item_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = s1_move ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_lvl_r <= levels;
    end
    if (s1_move && s1_valid_r) begin
      out_lvl_r  <= s1_lvl_r;
      out_data_r <= rd_data;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sensor_clock  = out_lvl_r.sensor_clock;
  assign out_ch.start_pulse   = out_lvl_r.start_pulse;
  assign out_ch.convert_start = out_lvl_r.convert_start;
  assign out_ch.pixel_data    = out_data_r;

endmodule

// ===== verif/line_camera_readout_sequencer_test.sv =====
`timescale 1ns / 1ps
module line_camera_readout_sequencer_test;
  import lcrs_pkg::*;

  localparam int LINE_PIXELS = LINE_PIXELS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [APB_ADDR_W-1:0] FRAME_END_ADDR = {REG_FRAME_END, 2'b00};

  typedef struct {
    logic              clk_level;
    logic              si_level;
    logic              convert;
    logic [DATA_W-1:0] pixel;
  } readout_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  lcrs_in_if  in_ch();
  lcrs_out_if out_ch();

  line_camera_readout_sequencer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted sequencer state.
  phase_t            m_phase;
  logic              m_clk;
  logic              m_si;
  logic [CNT_W-1:0]  m_count;
  logic              m_half;
  logic [DATA_W-1:0] m_store [2*LINE_PIXELS];
  logic [CNT_W-1:0]  m_frame_end;
  bit                sample_wanted;

  readout_t due_readouts[$];
  int failures;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    failures++;
    if (failures <= SHOWN_MISMATCHES)
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
  endtask

  // Applies one accepted item to the predicted state and queues its readout.
  task automatic advance_sequencer(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] sample,
                                   input logic [PIX_IDX_W-1:0] idx);
    readout_t r;
    r.convert = 1'b0;
    r.pixel = '0;
    case (op)
      OP_TICK: begin
        m_clk = ~m_clk;
        case (m_phase)
          PH_START: begin
            if (!m_clk) begin
              m_si = 1'b1;
              m_count = '0;
              m_phase = PH_DROP;
              sample_wanted = 1'b0;
            end
          end
          PH_DROP: begin
            if (m_clk) begin
              m_si = 1'b0;
              m_phase = PH_READ;
            end
          end
          PH_READ: begin
            if (!m_clk) begin
              r.convert = 1'b1;
              // The tick that finds the line full still converts, then swaps.
              if (m_count >= LINE_PIXELS) begin
                m_half = ~m_half;
                m_phase = PH_WAIT;
                sample_wanted = 1'b0;
              end else begin
                sample_wanted = 1'b1;
              end
            end
          end
          default: begin
            if (m_clk) begin
              m_count = m_count + 1'b1;
              if (m_count >= m_frame_end) m_phase = PH_START;
            end
          end
        endcase
      end
      OP_SAMPLE: begin
        if (m_count < LINE_PIXELS) begin
          m_store[m_half * LINE_PIXELS + m_count] = sample;
          m_count = m_count + 1'b1;
          sample_wanted = 1'b0;
        end
      end
      OP_READ: begin
        if (idx < LINE_PIXELS) r.pixel = m_store[(m_half ^ 1'b1) * LINE_PIXELS + idx];
      end
      default: ;
    endcase
    r.clk_level = m_clk;
    r.si_level = m_si;
    due_readouts.push_back(r);
  endtask

  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] sample,
                           input logic [PIX_IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.sample_value <= sample;
    in_ch.pixel_index <= idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_sequencer(op, sample, idx);
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_ch.valid <= 1'b0;
    while (due_readouts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_transfer(input bit write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= FRAME_END_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    if (write) m_frame_end = wdata[CNT_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_frame_end;
    logic [APB_DATA_W-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata[CNT_W-1:0] !== m_frame_end)
      flag_mismatch("frame_end_count", 32'(m_frame_end), rdata);
  endtask

  task automatic set_frame_end(input logic [CNT_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    apb_transfer(1'b1, APB_DATA_W'(value), rdata);
    check_frame_end();
  endtask

  // Mostly well-formed readout: each convert request is answered by one sample.
  task automatic drive_traffic(input int budget, input bit stop_in_wait, input int noise_pct);
    int sent;
    int pick;
    logic [DATA_W-1:0] value;
    sent = 0;
    while (sent < budget && !(stop_in_wait && m_phase == PH_WAIT)) begin
      pick = $urandom_range(99);
      case ($urandom_range(15))
        0: value = '0;
        1: value = '1;
        default: value = DATA_W'($urandom);
      endcase
      if (pick < noise_pct)
        send_item(OPC_W'($urandom_range(3)), value, PIX_IDX_W'($urandom_range(255)));
      else if (pick < noise_pct + 10)
        send_item(OP_READ, value,
                  PIX_IDX_W'(($urandom_range(7) == 0) ? $urandom_range(255, 128)
                                                      : $urandom_range(127)));
      else if (sample_wanted)
        send_item(OP_SAMPLE, value, PIX_IDX_W'($urandom_range(255)));
      else
        send_item(OP_TICK, value, PIX_IDX_W'($urandom_range(255)));
      sent++;
    end
  endtask

  task automatic test_after_reset;
    check_frame_end();
    send_item(OP_READ, DATA_W'($urandom), 8'd0);
    send_item(OP_READ, DATA_W'($urandom), 8'd127);
    send_item(OP_READ, DATA_W'($urandom), 8'd128);
    send_item(OP_READ, DATA_W'($urandom), 8'd255);
    send_item(2'd3, 16'hFFFF, 8'hFF);
    send_item(2'd3, 16'h0000, 8'h00);
    // Samples are taken before the first start pulse while the count is low.
    send_item(OP_SAMPLE, 16'hFFFF, 8'hFF);
    send_item(OP_SAMPLE, 16'h0000, 8'h00);
    repeat (3) send_item(OP_TICK, DATA_W'($urandom), PIX_IDX_W'($urandom));
    send_item(OP_SAMPLE, 16'hA5A5, PIX_IDX_W'($urandom));
    send_item(OP_READ, DATA_W'($urandom), 8'd0);
  endtask

  task automatic test_frame_end_limits;
    drain_results();
    set_frame_end(12'd4095);
    drive_traffic(2000, 1'b1, 0);
    // The line is full now: this sample must be dropped.
    send_item(OP_SAMPLE, 16'h1234, PIX_IDX_W'($urandom));
    send_item(OP_READ, DATA_W'($urandom), 8'd0);
    send_item(OP_READ, DATA_W'($urandom), 8'd127);
    send_item(OP_READ, DATA_W'($urandom), 8'd128);
    send_item(OP_READ, DATA_W'($urandom), 8'd255);
    repeat (60) send_item(OP_TICK, DATA_W'($urandom), PIX_IDX_W'($urandom));
    drain_results();
    // A limit below the current count ends the wait on the next high tick.
    set_frame_end(12'd129);
    repeat (4) send_item(OP_TICK, DATA_W'($urandom), PIX_IDX_W'($urandom));
  endtask

  task automatic test_random_traffic;
    drain_results();
    send_idle_pct = 29;
    recv_idle_pct = 48;
    set_frame_end(12'd129);
    drive_traffic(220, 1'b0, 5);
    drain_results();
    send_idle_pct = 48;
    recv_idle_pct = 29;
    set_frame_end(CNT_W'($urandom_range(200, 130)));
    drive_traffic(220, 1'b0, 5);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_frame_end(CNT_W'($urandom_range(160, 129)));
    drive_traffic(220, 1'b0, 5);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    readout_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_readouts.size() == 0) begin
        flag_mismatch("result with nothing due", 32'd0, 32'(out_ch.pixel_data));
      end else begin
        want = due_readouts.pop_front();
        if (out_ch.sensor_clock !== want.clk_level)
          flag_mismatch("sensor_clock", 32'(want.clk_level), 32'(out_ch.sensor_clock));
        if (out_ch.start_pulse !== want.si_level)
          flag_mismatch("start_pulse", 32'(want.si_level), 32'(out_ch.start_pulse));
        if (out_ch.convert_start !== want.convert)
          flag_mismatch("convert_start", 32'(want.convert), 32'(out_ch.convert_start));
        if (out_ch.pixel_data !== want.pixel)
          flag_mismatch("pixel_data", 32'(want.pixel), 32'(out_ch.pixel_data));
      end
    end
  end

  initial begin
    cycle_count = 0;
    failures = 0;
    send_idle_pct = 29;
    recv_idle_pct = 48;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_TICK;
    in_ch.sample_value = '0;
    in_ch.pixel_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    m_phase = PH_START;
    m_clk = 1'b0;
    m_si = 1'b0;
    m_count = '0;
    m_half = 1'b0;
    m_frame_end = FRAME_END_RESET;
    sample_wanted = 1'b0;
    foreach (m_store[i]) m_store[i] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_after_reset();
    test_frame_end_limits();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk);
    if (failures == 0 && due_readouts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== line_camera_readout_sequencer.f =====
+incdir+rtl
rtl/lcrs_pkg.sv
rtl/lcrs_if.sv
rtl/lcrs_ctrl.sv
rtl/lcrs_store.sv
rtl/line_camera_readout_sequencer.sv
verif/line_camera_readout_sequencer_test.sv
